FILE: design/stp_pkg.sv
package stp_pkg;

  // Table sizes
  localparam int FreqPoints = 38;
  localparam int KpaPoints  = 9;

  // Frequency clamp limits and the scale of the compensation factor
  localparam logic [19:0] OneMhz   = 20'd1000000;
  localparam logic [19:0] FreqMin  = 20'd48;
  localparam logic [19:0] FreqMax  = 20'd13233;
  localparam logic [13:0] CompBase = 14'd9570;
  localparam logic [13:0] CompScale = 14'd10000;

  // Configuration register indexes
  localparam logic [1:0] RegDefTemp = 2'd0;
  localparam logic [1:0] RegResFloor = 2'd1;
  localparam logic [1:0] RegResCeil = 2'd2;

  // Frequency breakpoints in Hz.
  function automatic logic [13:0] freq_pt(input logic [5:0] idx);
    logic [13:0] v;
    case (idx)
      6'd0: v = 14'd48;     6'd1: v = 14'd76;     6'd2: v = 14'd85;
      6'd3: v = 14'd103;    6'd4: v = 14'd122;    6'd5: v = 14'd157;
      6'd6: v = 14'd194;    6'd7: v = 14'd264;    6'd8: v = 14'd335;
      6'd9: v = 14'd476;    6'd10: v = 14'd612;   6'd11: v = 14'd874;
      6'd12: v = 14'd1135;  6'd13: v = 14'd1623;  6'd14: v = 14'd2071;
      6'd15: v = 14'd2862;  6'd16: v = 14'd3557;  6'd17: v = 14'd4697;
      6'd18: v = 14'd5596;  6'd19: v = 14'd6932;  6'd20: v = 14'd7878;
      6'd21: v = 14'd9104;  6'd22: v = 14'd9882;  6'd23: v = 14'd10802;
      6'd24: v = 14'd11312; 6'd25: v = 14'd11893; 6'd26: v = 14'd12200;
      6'd27: v = 14'd12526; 6'd28: v = 14'd12708; 6'd29: v = 14'd12871;
      6'd30: v = 14'd12962; 6'd31: v = 14'd13047; 6'd32: v = 14'd13092;
      6'd33: v = 14'd13139; 6'd34: v = 14'd13162; 6'd35: v = 14'd13186;
      6'd36: v = 14'd13209; 6'd37: v = 14'd13233;
      default: v = 14'd13233;
    endcase
    return v;
  endfunction

  // Sensor resistance in ohms at each frequency breakpoint.
  function automatic logic [23:0] ohm_pt(input logic [5:0] idx);
    logic [23:0] v;
    case (idx)
      6'd0: v = 24'd10000000; 6'd1: v = 24'd262144; 6'd2: v = 24'd196608;
      6'd3: v = 24'd131072;   6'd4: v = 24'd98304;  6'd5: v = 24'd65536;
      6'd6: v = 24'd49152;    6'd7: v = 24'd32768;  6'd8: v = 24'd24567;
      6'd9: v = 24'd16384;    6'd10: v = 24'd12288; 6'd11: v = 24'd8192;
      6'd12: v = 24'd6144;    6'd13: v = 24'd4096;  6'd14: v = 24'd3072;
      6'd15: v = 24'd2048;    6'd16: v = 24'd1536;  6'd17: v = 24'd1024;
      6'd18: v = 24'd768;     6'd19: v = 24'd512;   6'd20: v = 24'd384;
      6'd21: v = 24'd256;     6'd22: v = 24'd192;   6'd23: v = 24'd128;
      6'd24: v = 24'd96;      6'd25: v = 24'd64;    6'd26: v = 24'd48;
      6'd27: v = 24'd32;      6'd28: v = 24'd24;    6'd29: v = 24'd16;
      6'd30: v = 24'd12;      6'd31: v = 24'd8;     6'd32: v = 24'd6;
      6'd33: v = 24'd4;       6'd34: v = 24'd3;     6'd35: v = 24'd2;
      6'd36: v = 24'd1;       6'd37: v = 24'd0;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // Resistance breakpoints of the tension curve in ohms.
  function automatic logic [14:0] kpa_ohm_pt(input logic [3:0] idx);
    logic [14:0] v;
    case (idx)
      4'd0: v = 15'd550;   4'd1: v = 15'd1000;  4'd2: v = 15'd1100;
      4'd3: v = 15'd2000;  4'd4: v = 15'd6000;  4'd5: v = 15'd9200;
      4'd6: v = 15'd12200; 4'd7: v = 15'd15575; 4'd8: v = 15'd27950;
      default: v = 15'd27950;
    endcase
    return v;
  endfunction

  // Tension in kPa at each resistance breakpoint.
  function automatic logic [7:0] kpa_pt(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0: v = 8'd0;   4'd1: v = 8'd9;   4'd2: v = 8'd10;
      4'd3: v = 8'd15;  4'd4: v = 8'd35;  4'd5: v = 8'd55;
      4'd6: v = 8'd75;  4'd7: v = 8'd100; 4'd8: v = 8'd200;
      default: v = 8'd200;
    endcase
    return v;
  endfunction

  // Resistance breakpoint scaled by the compensation scale.
  function automatic logic [37:0] kpa_ohm_scaled(input logic [3:0] idx);
    return 38'(kpa_ohm_pt(idx)) * 38'(CompScale);
  endfunction

endpackage

FILE: design/stp_div.sv
// Restoring divider that produces one quotient bit per cycle.
// The caller supplies the upper part of the dividend as the starting
// remainder and the lower part left-aligned; the quotient must fit in
// the given number of steps.
module stp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [34:0] rem_init_i,
  input  logic [23:0] low_i,
  input  logic [4:0]  steps_i,
  input  logic [34:0] den_i,
  output logic        done_o,
  output logic [23:0] quo_o,
  output logic [34:0] rem_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [34:0] rem_q, rem_d;
  logic [23:0] low_q, low_d;
  logic [23:0] quo_q, quo_d;
  logic [34:0] den_q, den_d;
  logic        done_q, done_d;
  logic [35:0] trial;
  logic        ge;

  // One shift-and-subtract step.
  assign trial = {rem_q, low_q[23]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_init_i;
      low_d  = low_i;
      quo_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? 35'(trial - {1'b0, den_q}) : trial[34:0];
      low_d = {low_q[22:0], 1'b0};
      quo_d = {quo_q[22:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/soil_tension_from_pulse_period_core.sv
// Soil water tension from the pulse period of a resistive sensor oscillator.
//
// Input channel (in_valid_i / in_ready_o) carries one transaction per reading:
// high and low pulse widths in microseconds and the soil temperature.
// Output channel (out_valid_o / out_ready_i) returns one transaction per input
// with the validity flag, frequency, clamped resistance and tension in kPa.
// A reading with a zero pulse width goes straight to the final state and
// returns with all fields zero. Otherwise a valid reading passes through
// these steps in order: a 20-step period division, a search of up to 37
// frequency segments at one per cycle, a 24-step interpolation division, a
// search of up to 8 tension segments and, unless the tension saturates, an
// 8-step division, all sharing one bit-serial divider.
// One reading is processed at a time; in_ready_o is high only while idle.
// If the receiver stalls, the finished result waits in the output register;
// the next result then waits in the final state until that one is taken.
// Reset empties the block and loads the default configuration: default
// temperature 24 C, resistance floor 550 ohms, ceiling 27950 ohms.
// Registers are written through the APB port at byte addresses 0, 4 and 8.
module soil_tension_from_pulse_period_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [19:0] high_time_us_i,
  input  logic [19:0] low_time_us_i,
  input  logic signed [7:0] soil_temp_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [18:0] frequency_hz_o,
  output logic [23:0] resistance_ohms_o,
  output logic [7:0]  tension_kpa_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv1S = 4'd1;
  localparam logic [3:0] StDiv1W = 4'd2;
  localparam logic [3:0] StSrch  = 4'd3;
  localparam logic [3:0] StLoP   = 4'd4;
  localparam logic [3:0] StDenP  = 4'd5;
  localparam logic [3:0] StNumP  = 4'd6;
  localparam logic [3:0] StDiv2S = 4'd7;
  localparam logic [3:0] StDiv2W = 4'd8;
  localparam logic [3:0] StMul   = 4'd9;
  localparam logic [3:0] StKSrch = 4'd10;
  localparam logic [3:0] StKNum  = 4'd11;
  localparam logic [3:0] StDiv3S = 4'd12;
  localparam logic [3:0] StDiv3W = 4'd13;
  localparam logic [3:0] StFin   = 4'd14;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic signed [7:0] def_temp_q;
  logic [23:0] res_floor_q;
  logic [23:0] res_ceil_q;

  // Working registers
  logic signed [7:0] temp_q, temp_d;
  logic [20:0] period_q, period_d;
  logic        ok_q, ok_d;
  logic [18:0] freq_q, freq_d;
  logic [19:0] n_q, n_d;
  logic [20:0] d_q, d_d;
  logic [5:0]  seg_q, seg_d;
  logic [34:0] lo_prod_q, lo_prod_d;
  logic [19:0] diff_q, diff_d;
  logic [34:0] den2_q, den2_d;
  logic [43:0] num2_q, num2_d;
  logic [23:0] ohms_q, ohms_d;
  logic [37:0] m_q, m_d;
  logic [3:0]  kseg_q, kseg_d;
  logic [33:0] num3_q, num3_d;
  logic [7:0]  kpa_q, kpa_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic        res_ok_q;
  logic [18:0] res_freq_q;
  logic [23:0] res_ohms_q;
  logic [7:0]  res_kpa_q;
  logic        load_out;

  // Divider interface
  logic        div_start;
  logic [34:0] div_rem_init;
  logic [23:0] div_low;
  logic [4:0]  div_steps;
  logic [34:0] div_den;
  logic        div_done;
  logic [23:0] div_quo;
  logic [34:0] div_rem;

  // Datapath helpers
  logic [5:0]  seg_nx;
  logic [3:0]  kseg_nx;
  logic [34:0] seg_hi_prod;
  logic [44:0] num2_adj;
  logic [23:0] ohm_seg;
  logic [23:0] ohm_interp;
  logic signed [7:0] t_eff;
  logic signed [7:0] t_sat;
  logic signed [14:0] fac_s;
  logic [26:0] kdiff;
  logic [26:0] kden;
  logic [6:0]  kdk;

  assign seg_nx  = seg_q + 6'd1;
  assign kseg_nx = kseg_q + 4'd1;

  // Upper bound of the current frequency segment, scaled by the divisor.
  assign seg_hi_prod = 35'(stp_pkg::freq_pt(seg_nx)) * 35'(d_q);

  // Dividend of the interpolation, biased so that the quotient rounds up.
  assign num2_adj = 45'(num2_q) + 45'(den2_q) - 45'd1;

  // Interpolated resistance, never below zero.
  assign ohm_seg    = stp_pkg::ohm_pt(seg_q);
  assign ohm_interp = (div_quo >= ohm_seg) ? 24'd0 : ohm_seg - div_quo;

  // Effective temperature, saturated, and the compensation factor.
  assign t_eff = (temp_q == 8'sd0) ? def_temp_q : temp_q;
  always_comb begin
    if (t_eff < -8'sd50) begin
      t_sat = -8'sd50;
    end else if (t_eff > 8'sd100) begin
      t_sat = 8'sd100;
    end else begin
      t_sat = t_eff;
    end
  end
  assign fac_s = $signed({1'b0, stp_pkg::CompBase}) + 15'(t_sat) * 15'sd18;

  // Tension segment terms.
  assign kdiff = 27'(m_q - stp_pkg::kpa_ohm_scaled(kseg_q));
  assign kden  = 27'(stp_pkg::kpa_ohm_scaled(kseg_nx) - stp_pkg::kpa_ohm_scaled(kseg_q));
  assign kdk   = 7'(stp_pkg::kpa_pt(kseg_nx) - stp_pkg::kpa_pt(kseg_q));

  // Divider operand selection for the three divisions.
  always_comb begin
    div_start    = 1'b0;
    div_rem_init = '0;
    div_low      = {4'(stp_pkg::OneMhz >> 16), stp_pkg::OneMhz[15:0], 4'd0};
    div_steps    = 5'd20;
    div_den      = 35'(period_q);
    case (state_q)
      StDiv1S: begin
        div_start = 1'b1;
      end
      StDiv2S: begin
        div_start    = 1'b1;
        div_rem_init = 35'(num2_adj[44:24]);
        div_low      = num2_adj[23:0];
        div_steps    = 5'd24;
        div_den      = den2_q;
      end
      StDiv3S: begin
        div_start    = 1'b1;
        div_rem_init = 35'(num3_q[33:8]);
        div_low      = {num3_q[7:0], 16'd0};
        div_steps    = 5'd8;
        div_den      = 35'(kden);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  stp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .low_i      (div_low),
    .steps_i    (div_steps),
    .den_i      (div_den),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    temp_d    = temp_q;
    period_d  = period_q;
    ok_d      = ok_q;
    freq_d    = freq_q;
    n_d       = n_q;
    d_d       = d_q;
    seg_d     = seg_q;
    lo_prod_d = lo_prod_q;
    diff_d    = diff_q;
    den2_d    = den2_q;
    num2_d    = num2_q;
    ohms_d    = ohms_q;
    m_d       = m_q;
    kseg_d    = kseg_q;
    num3_d    = num3_q;
    kpa_d     = kpa_q;
    load_out  = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          temp_d   = soil_temp_c_i;
          period_d = 21'(high_time_us_i) + 21'(low_time_us_i);
          if (high_time_us_i == 20'd0 || low_time_us_i == 20'd0) begin
            ok_d    = 1'b0;
            freq_d  = '0;
            ohms_d  = '0;
            kpa_d   = '0;
            state_d = StFin;
          end else begin
            ok_d    = 1'b1;
            state_d = StDiv1S;
          end
        end
      end
      StDiv1S: begin
        state_d = StDiv1W;
      end
      StDiv1W: begin
        if (div_done) begin
          freq_d = div_quo[18:0];
          seg_d  = '0;
          if (div_quo[19:0] < stp_pkg::FreqMin) begin
            n_d = stp_pkg::FreqMin;
            d_d = 21'd1;
          end else if (div_quo[19:0] > stp_pkg::FreqMax ||
                       (div_quo[19:0] == stp_pkg::FreqMax && div_rem != '0)) begin
            n_d = stp_pkg::FreqMax;
            d_d = 21'd1;
          end else begin
            n_d = stp_pkg::OneMhz;
            d_d = period_q;
          end
          state_d = StSrch;
        end
      end
      StSrch: begin
        if (35'(n_q) <= seg_hi_prod) begin
          state_d = StLoP;
        end else begin
          seg_d = seg_nx;
        end
      end
      StLoP: begin
        lo_prod_d = 35'(stp_pkg::freq_pt(seg_q)) * 35'(d_q);
        state_d   = StDenP;
      end
      StDenP: begin
        diff_d  = n_q - lo_prod_q[19:0];
        den2_d  = 35'(d_q) *
                  35'(stp_pkg::freq_pt(seg_nx) - stp_pkg::freq_pt(seg_q));
        state_d = StNumP;
      end
      StNumP: begin
        num2_d  = 44'(stp_pkg::ohm_pt(seg_q) - stp_pkg::ohm_pt(seg_nx)) * 44'(diff_q);
        state_d = StDiv2S;
      end
      StDiv2S: begin
        state_d = StDiv2W;
      end
      StDiv2W: begin
        if (div_done) begin
          if (ohm_interp < res_floor_q) begin
            ohms_d = res_floor_q;
          end else if (ohm_interp > res_ceil_q) begin
            ohms_d = res_ceil_q;
          end else begin
            ohms_d = ohm_interp;
          end
          state_d = StMul;
        end
      end
      StMul: begin
        m_d     = 38'(ohms_q) * 38'(fac_s[13:0]);
        kseg_d  = '0;
        state_d = StKSrch;
      end
      StKSrch: begin
        if (m_q <= stp_pkg::kpa_ohm_scaled(4'd0)) begin
          kpa_d   = stp_pkg::kpa_pt(4'd0);
          state_d = StFin;
        end else if (m_q >= stp_pkg::kpa_ohm_scaled(4'(stp_pkg::KpaPoints - 1))) begin
          kpa_d   = stp_pkg::kpa_pt(4'(stp_pkg::KpaPoints - 1));
          state_d = StFin;
        end else if (m_q <= stp_pkg::kpa_ohm_scaled(kseg_nx)) begin
          state_d = StKNum;
        end else begin
          kseg_d = kseg_nx;
        end
      end
      StKNum: begin
        num3_d  = 34'(kdk) * 34'(kdiff);
        state_d = StDiv3S;
      end
      StDiv3S: begin
        state_d = StDiv3W;
      end
      StDiv3W: begin
        if (div_done) begin
          kpa_d   = stp_pkg::kpa_pt(kseg_q) + div_quo[7:0];
          state_d = StFin;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output transaction holds until taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q    <= temp_d;
    period_q  <= period_d;
    ok_q      <= ok_d;
    freq_q    <= freq_d;
    n_q       <= n_d;
    d_q       <= d_d;
    seg_q     <= seg_d;
    lo_prod_q <= lo_prod_d;
    diff_q    <= diff_d;
    den2_q    <= den2_d;
    num2_q    <= num2_d;
    ohms_q    <= ohms_d;
    m_q       <= m_d;
    kseg_q    <= kseg_d;
    num3_q    <= num3_d;
    kpa_q     <= kpa_d;
    if (load_out) begin
      res_ok_q   <= ok_q;
      res_freq_q <= freq_q;
      res_ohms_q <= ohms_q;
      res_kpa_q  <= kpa_q;
    end
  end

  assign in_ready_o        = (state_q == StIdle);
  assign out_valid_o       = out_valid_q;
  assign valid_res_o       = res_ok_q;
  assign frequency_hz_o    = res_freq_q;
  assign resistance_ohms_o = res_ohms_q;
  assign tension_kpa_o     = res_kpa_q;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_temp_q  <= 8'sd24;
      res_floor_q <= 24'd550;
      res_ceil_q  <= 24'd27950;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        stp_pkg::RegDefTemp:  def_temp_q  <= pwdata[7:0];
        stp_pkg::RegResFloor: res_floor_q <= pwdata[23:0];
        stp_pkg::RegResCeil:  res_ceil_q  <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      stp_pkg::RegDefTemp:  prdata = 32'(def_temp_q);
      stp_pkg::RegResFloor: prdata = 32'(res_floor_q);
      stp_pkg::RegResCeil:  prdata = 32'(res_ceil_q);
      default:              prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule

FILE: bench/tb_soil_tension_from_pulse_period_core.sv
`timescale 1ns / 1ps

module tb_soil_tension_from_pulse_period_core;

  // Clock, reset and block ports.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [19:0] high_time_us_i = '0;
  logic [19:0] low_time_us_i = '0;
  logic signed [7:0] soil_temp_c_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  logic [18:0] frequency_hz_o;
  logic [23:0] resistance_ohms_o;
  logic [7:0]  tension_kpa_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  typedef struct packed {
    logic        ok;
    logic [18:0] freq;
    logic [23:0] ohms;
    logic [7:0]  kpa;
  } reading_t;

  reading_t    pending_readings[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          idle_enable = 1'b1;
  int          hold_cycles = 0;
  bit          long_hold_go = 1'b0;
  bit          long_hold = 1'b0;

  // Predictor copy of the configuration.
  int          cfg_def_temp = 24;
  longint      cfg_floor = 550;
  longint      cfg_ceil = 27950;

  soil_tension_from_pulse_period_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle limit on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Frequency in n/d to interpolated resistance.
  function automatic longint interp_ohms(longint n, longint d);
    longint lo, hi, df, dr, x;
    for (int i = 0; i + 1 < stp_pkg::FreqPoints; i++) begin
      lo = longint'(stp_pkg::freq_pt(6'(i))) * d;
      hi = longint'(stp_pkg::freq_pt(6'(i + 1))) * d;
      if (lo <= n && n <= hi) begin
        df = longint'(stp_pkg::freq_pt(6'(i + 1))) - longint'(stp_pkg::freq_pt(6'(i)));
        dr = longint'(stp_pkg::ohm_pt(6'(i))) - longint'(stp_pkg::ohm_pt(6'(i + 1)));
        if (df == 0 || dr < 0) return stp_pkg::ohm_pt(6'(i));
        x = (dr * (n - lo) + d * df - 1) / (d * df);
        return (x >= stp_pkg::ohm_pt(6'(i))) ? 0 : longint'(stp_pkg::ohm_pt(6'(i))) - x;
      end
    end
    return 0;
  endfunction

  // Compensated resistance (scaled by 10000) to tension.
  function automatic longint interp_kpa(longint m);
    longint lo, hi, dr, dk;
    if (m <= 550 * 10000) return 0;
    if (m >= 27950 * 10000) return 200;
    for (int i = 0; i + 1 < stp_pkg::KpaPoints; i++) begin
      lo = longint'(stp_pkg::kpa_ohm_pt(4'(i))) * 10000;
      hi = longint'(stp_pkg::kpa_ohm_pt(4'(i + 1))) * 10000;
      if (lo <= m && m <= hi) begin
        dr = longint'(stp_pkg::kpa_ohm_pt(4'(i + 1))) - longint'(stp_pkg::kpa_ohm_pt(4'(i)));
        dk = longint'(stp_pkg::kpa_pt(4'(i + 1))) - longint'(stp_pkg::kpa_pt(4'(i)));
        return longint'(stp_pkg::kpa_pt(4'(i))) + (dk * (m - lo)) / (dr * 10000);
      end
    end
    return 200;
  endfunction

  function automatic reading_t predict_reading(logic [19:0] ht, logic [19:0] lt,
                                                logic signed [7:0] tc);
    reading_t r;
    longint p, n, d, ohms;
    int t;
    r = '0;
    if (ht == 0 || lt == 0) return r;
    p = longint'(ht) + longint'(lt);
    r.ok = 1'b1;
    r.freq = 19'(1000000 / p);
    if (1000000 < 48 * p) begin n = 48; d = 1; end
    else if (1000000 > 13233 * p) begin n = 13233; d = 1; end
    else begin n = 1000000; d = p; end
    ohms = interp_ohms(n, d);
    if (ohms < cfg_floor) ohms = cfg_floor;
    else if (ohms > cfg_ceil) ohms = cfg_ceil;
    t = int'(tc);
    if (t == 0) t = cfg_def_temp;
    if (t < -50) t = -50;
    if (t > 100) t = 100;
    r.ohms = 24'(ohms);
    r.kpa = 8'(interp_kpa(ohms * (9570 + 18 * t)));
    return r;
  endfunction

  // Input monitor: each accepted transaction queues its expected reading.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o)
      pending_readings.push_back(predict_reading(high_time_us_i, low_time_us_i,
                                                 soil_temp_c_i));
  end

  // Output checker: compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    reading_t exp_r, got_r;
    if (out_valid_o && out_ready_i) begin
      got_r = {valid_res_o, frequency_hz_o, resistance_ohms_o, tension_kpa_o};
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got_r);
        fail_count++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (got_r.ok !== exp_r.ok) begin
          $display("%0t: valid_res exp %0d got %0d", $time, exp_r.ok, got_r.ok);
          fail_count++;
        end
        if (got_r.freq !== exp_r.freq) begin
          $display("%0t: frequency exp %0d got %0d", $time, exp_r.freq, got_r.freq);
          fail_count++;
        end
        if (got_r.ohms !== exp_r.ohms) begin
          $display("%0t: resistance exp %0d got %0d", $time, exp_r.ohms, got_r.ohms);
          fail_count++;
        end
        if (got_r.kpa !== exp_r.kpa) begin
          $display("%0t: tension exp %0d got %0d", $time, exp_r.kpa, got_r.kpa);
          fail_count++;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once it is requested.
  initial begin
    wait (long_hold_go);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (600) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // Receiver: random stall bursts, or the long hold-off while it runs.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (long_hold) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 3) == 0) begin
      hold_cycles <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Send one reading and wait for its acceptance.
  task automatic send_reading(logic [19:0] ht, logic [19:0] lt, logic signed [7:0] tc);
    int gap;
    if (idle_enable && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    high_time_us_i <= ht;
    low_time_us_i <= lt;
    soil_temp_c_i <= tc;
    do @(posedge clk_i); while (!(in_ready_o === 1'b1));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  // Register write through the APB port; updates the predictor copy too.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!(pready === 1'b1));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      stp_pkg::RegDefTemp: cfg_def_temp = int'($signed(value[7:0]));
      stp_pkg::RegResFloor: cfg_floor = longint'(value[23:0]);
      default: cfg_ceil = longint'(value[23:0]);
    endcase
  endtask

  function automatic logic [19:0] rand_width();
    case ($urandom_range(0, 5))
      0: return 20'($urandom_range(1, 20));
      1: return 20'($urandom_range(1, 200));
      2: return 20'($urandom_range(30, 12000));
      3: return 20'($urandom);
      4: return 20'($urandom_range(0, 1) ? 0 : 20'hFFFFF);
      default: return 20'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++)
      send_reading(rand_width(), rand_width(), 8'($urandom));
  endtask

  // Extremes, the error cases and the clamping corners.
  task automatic test_directed();
    send_reading(20'd0, 20'd100, 8'sd20);
    send_reading(20'd100, 20'd0, 8'sd20);
    send_reading(20'd0, 20'd0, 8'sd0);
    send_reading(20'd1, 20'd1, 8'sd0);
    send_reading(20'd37, 20'd38, 8'sd25);
    send_reading(20'd10416, 20'd10417, 8'sd25);
    send_reading(20'hFFFFF, 20'hFFFFF, -8'sd128);
    send_reading(20'd1000000, 20'd1000000, 8'sd127);
    send_reading(20'd500, 20'd500, 8'sd0);
    send_reading(20'd250, 20'd250, -8'sd50);
    send_reading(20'd250, 20'd250, 8'sd100);
    send_reading(20'd2000, 20'd2000, 8'sd24);
    send_reading(20'd150, 20'd150, -8'sd1);
    send_reading(20'd900, 20'd1100, 8'sd1);
    send_reading(20'd40, 20'd60, 8'sd10);
    wait_drained();
  endtask

  // Several configurations, including the extremes and floor above ceiling.
  task automatic test_config_sweep();
    write_register(stp_pkg::RegDefTemp, 32'hFFFF_FFCE);
    write_register(stp_pkg::RegResFloor, 32'd0);
    write_register(stp_pkg::RegResCeil, 32'd10000000);
    run_random(80);
    wait_drained();
    write_register(stp_pkg::RegDefTemp, 32'd100);
    write_register(stp_pkg::RegResFloor, 32'd20000);
    write_register(stp_pkg::RegResCeil, 32'd1000);
    run_random(60);
    wait_drained();
    write_register(stp_pkg::RegDefTemp, 32'h0000_0080);
    write_register(stp_pkg::RegResFloor, 32'hFFFF_FFFF);
    write_register(stp_pkg::RegResCeil, 32'h00FF_FFFF);
    run_random(40);
    wait_drained();
    write_register(stp_pkg::RegDefTemp, 32'h0000_007F);
    write_register(stp_pkg::RegResFloor, 32'd550);
    write_register(stp_pkg::RegResCeil, 32'd27950);
    run_random(60);
    wait_drained();
  endtask

  // Long receiver hold-off while the sender keeps offering.
  task automatic test_backpressure();
    long_hold_go = 1'b1;
    run_random(20);
  endtask

  task automatic test_random_mix();
    run_random(150);
    idle_enable = 1'b0;
    run_random(80);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random_mix();
    wait_drained();
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
